/* sv/rbsp_pkg.sv */
// Shared types, constants and helpers for the ray bounding-sphere nearest pick.
// No dependencies; imported by every module of the block.
package rbsp_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [30:0] MAX31   = 31'h7FFF_FFFF;
    localparam logic [30:0] HALF_Q  = 31'h0000_8000;
    localparam logic [17:0] DIR_ONE = 18'h1_0000;

    // Multiplier step tags: box squares, |oc| squares, dot terms, b^2, r^2
    localparam logic [3:0] MUL_BOX_LAST = 4'd2;
    localparam logic [3:0] MUL_OCC_LAST = 4'd5;
    localparam logic [3:0] MUL_DOT_LAST = 4'd8;
    localparam logic [3:0] MUL_B        = 4'd9;
    localparam logic [3:0] MUL_R        = 4'd10;

    typedef enum logic [1:0] {
        KIND_SPHERE, KIND_BOX, KIND_CAPSULE, KIND_UNKNOWN
    } kind_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z, REG_DIR_X, REG_DIR_Y, REG_DIR_Z
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_RAD, ST_RADW, ST_B, ST_MUL2, ST_DISC, ST_CMP,
        ST_ROOT, ST_T, ST_PUSH
    } fsm_t;

    // One tested body as handed from front to back
    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
        logic [15:0] id;
        logic        last;
    } test_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -36'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* sv/rbsp_isqrt.sv */
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on rbsp_pkg only through the import convention.
module rbsp_isqrt
    import rbsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg;
    logic        done_reg;
    logic [63:0] trial;

    // One restoring step per cycle
    always_comb begin
        trial = res_reg + bit_reg;
        if (rem_reg >= trial) begin
            rem_next = rem_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end else begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
    end

    // Control: bit mask walks down two places a step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (bit_reg == 64'd1);
            if (start)
                bit_reg <= 64'h4000_0000_0000_0000;
            else
                bit_reg <= bit_reg >> 2;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= value;
            res_reg <= '0;
        end else if (bit_reg != '0) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

/* sv/rbsp_front.sv */
// Front end: holds ray registers, accepts bodies and runs the sphere test
// with one shared multiplier and the square root unit. Uses rbsp_pkg, rbsp_isqrt.
module rbsp_front
    import rbsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  kind_in,
    input  logic [30:0] dim_in [3],
    input  logic [31:0] center_in [3],
    input  logic [15:0] id_in,
    input  logic        last_in,
    input  logic        q_full,
    output logic        q_push,
    output test_t       q_data
);

    fsm_t state_reg, state_next;

    logic [31:0] org_reg [3];
    logic [17:0] dir_reg [3];

    kind_t       kind_reg;
    logic [30:0] dim_reg [3];
    logic [31:0] oc_reg  [3];
    logic [15:0] id_reg;
    logic        last_reg;

    logic [3:0]  cnt_reg;
    logic [31:0] op_a, op_b;
    logic        op_neg;
    logic        issue;
    logic [63:0] prod_reg;
    logic [3:0]  ptag_reg;
    logic        pneg_reg;
    logic        pvalid_reg;

    logic [63:0]        box_reg, occ_reg, p_reg;
    logic signed [51:0] dot_reg;
    logic signed [51:0] term;
    logic [30:0]        r_reg, r_simple;
    logic [31:0]        cap_sum;
    logic signed [31:0] b_reg;
    logic [31:0]        s_reg;
    logic               hit_reg;
    logic [30:0]        t_reg;

    logic signed [33:0] nb;
    logic signed [34:0] t0, t1, tv;
    logic               t_ok;

    logic        accept;
    logic        sq_start, sq_done;
    logic [63:0] sq_value;
    logic [31:0] sq_root;

    assign accept = s_valid && s_ready;

    // Ray registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DIR_ONE;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_addr))
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0] <= cfg_data[17:0];
                REG_DIR_Y:    dir_reg[1] <= cfg_data[17:0];
                REG_DIR_Z:    dir_reg[2] <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Capture the body and its offset from the origin
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind_t'(kind_in);
            id_reg   <= id_in;
            last_reg <= last_in;
            for (int i = 0; i < 3; i++) begin
                dim_reg[i] <= dim_in[i];
                oc_reg[i]  <= sat_s32(36'($signed(org_reg[i])) - 36'($signed(center_in[i])));
            end
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        case (cnt_reg)
            4'd0: begin op_a = {1'b0, dim_reg[0]}; op_b = op_a; end
            4'd1: begin op_a = {1'b0, dim_reg[1]}; op_b = op_a; end
            4'd2: begin op_a = {1'b0, dim_reg[2]}; op_b = op_a; end
            4'd3: begin op_a = mag32(oc_reg[0]); op_b = op_a; end
            4'd4: begin op_a = mag32(oc_reg[1]); op_b = op_a; end
            4'd5: begin op_a = mag32(oc_reg[2]); op_b = op_a; end
            4'd6: begin
                op_a   = mag32(oc_reg[0]);
                op_b   = mag32(32'($signed(dir_reg[0])));
                op_neg = oc_reg[0][31] ^ dir_reg[0][17];
            end
            4'd7: begin
                op_a   = mag32(oc_reg[1]);
                op_b   = mag32(32'($signed(dir_reg[1])));
                op_neg = oc_reg[1][31] ^ dir_reg[1][17];
            end
            4'd8: begin
                op_a   = mag32(oc_reg[2]);
                op_b   = mag32(32'($signed(dir_reg[2])));
                op_neg = oc_reg[2][31] ^ dir_reg[2][17];
            end
            4'd9:  begin op_a = mag32(b_reg); op_b = op_a; end
            4'd10: begin op_a = {1'b0, r_reg}; op_b = op_a; end
            default: ;
        endcase
    end

    // Multiplier stage and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            pvalid_reg <= issue;
            if (accept)
                cnt_reg <= '0;
            else if (issue)
                cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        ptag_reg <= cnt_reg;
        pneg_reg <= op_neg;
    end

    // Accumulate products by step tag
    assign term = {1'b0, prod_reg[50:0]};

    always_ff @(posedge aclk) begin
        if (accept) begin
            box_reg <= '0;
            occ_reg <= '0;
            dot_reg <= '0;
        end else if (pvalid_reg) begin
            if (ptag_reg <= MUL_BOX_LAST)
                box_reg <= box_reg + prod_reg;
            else if (ptag_reg <= MUL_OCC_LAST)
                occ_reg <= occ_reg + prod_reg;
            else if (ptag_reg <= MUL_DOT_LAST)
                dot_reg <= dot_reg + (pneg_reg ? -term : term);
            else if (ptag_reg == MUL_B)
                p_reg <= prod_reg;
            else
                p_reg <= p_reg + prod_reg;
        end
    end

    // Radius for shapes that need no root
    assign cap_sum = {1'b0, dim_reg[0]} + {1'b0, dim_reg[1]};

    always_comb begin
        case (kind_reg)
            KIND_SPHERE:  r_simple = dim_reg[0];
            KIND_CAPSULE: r_simple = cap_sum[31] ? MAX31 : cap_sum[30:0];
            KIND_UNKNOWN: r_simple = HALF_Q;
            default:      r_simple = '0;
        endcase
    end

    // Distance candidates from b and the root of the discriminant
    always_comb begin
        nb = -34'($signed(b_reg));
        t0 = 35'(nb) - $signed({3'b000, s_reg});
        t1 = 35'(nb) + $signed({3'b000, s_reg});
        t_ok = 1'b1;
        if (t0 > 0)
            tv = t0;
        else if (t1 > 0)
            tv = t1;
        else begin
            tv   = '0;
            t_ok = 1'b0;
        end
    end

    // Per-body datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RAD)
            r_reg <= r_simple;
        else if (state_reg == ST_RADW && sq_done)
            r_reg <= sq_root[31] ? MAX31 : sq_root[30:0];
        if (state_reg == ST_B)
            b_reg <= sat_s32(dot_reg[51:16]);
        if (state_reg == ST_ROOT && sq_done)
            s_reg <= sq_root;
        if (state_reg == ST_CMP)
            hit_reg <= 1'b0;
        else if (state_reg == ST_T) begin
            hit_reg <= t_ok;
            t_reg   <= (tv > 35'sd2147483647) ? MAX31 : tv[30:0];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == MUL_DOT_LAST) state_next = ST_RAD;
            ST_RAD:   state_next = (kind_reg == KIND_BOX) ? ST_RADW : ST_B;
            ST_RADW:  if (sq_done) state_next = ST_B;
            ST_B:     state_next = ST_MUL2;
            ST_MUL2:  if (cnt_reg == MUL_R) state_next = ST_DISC;
            ST_DISC:  state_next = ST_CMP;
            ST_CMP:   state_next = (p_reg < occ_reg) ? ST_PUSH : ST_ROOT;
            ST_ROOT:  if (sq_done) state_next = ST_T;
            ST_T:     state_next = ST_PUSH;
            ST_PUSH:  if (!q_full) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        issue    = (state_reg == ST_MUL) || (state_reg == ST_MUL2);
        sq_start = ((state_reg == ST_RAD) && (kind_reg == KIND_BOX)) ||
                   ((state_reg == ST_CMP) && (p_reg >= occ_reg));
        sq_value = (state_reg == ST_RAD) ? box_reg : (p_reg - occ_reg);
        q_push   = (state_reg == ST_PUSH) && !q_full;
    end

    assign q_data.hit      = hit_reg;
    assign q_data.distance = t_reg;
    assign q_data.id       = id_reg;
    assign q_data.last     = last_reg;

    rbsp_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   (sq_value),
        .done    (sq_done),
        .root    (sq_root)
    );

endmodule

/* sv/rbsp_queue.sv */
// Short queue of tested bodies between front and back end.
// Uses test_t from rbsp_pkg.
module rbsp_queue
    import rbsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  test_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output test_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    test_t            mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = mem[rptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push)
            mem[wptr_reg] <= push_data;
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !valid))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

/* sv/rbsp_back.sv */
// Back end: keeps the nearest hit of the scene and emits it on the last body.
// Uses test_t and MAX31 from rbsp_pkg.
module rbsp_back
    import rbsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  test_t       q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [15:0] m_id,
    output logic [30:0] m_dist
);

    logic        any_reg;
    logic [30:0] best_dist_reg;
    logic [15:0] best_id_reg;
    logic        m_valid_reg;
    logic        m_hit_reg;
    logic [15:0] m_id_reg;
    logic [30:0] m_dist_reg;

    logic        take, upd;
    logic        any_next;
    logic [30:0] dist_next;
    logic [15:0] id_next;

    // Pop a non-last body at once; a last body waits for the output slot
    assign take  = q_valid && (!q_head.last || !m_valid_reg || m_ready);
    assign q_pop = take;

    // Keep the strictly nearer hit, first hit always taken
    always_comb begin
        upd       = q_head.hit && (!any_reg || (q_head.distance < best_dist_reg));
        any_next  = any_reg || upd;
        dist_next = upd ? q_head.distance : best_dist_reg;
        id_next   = upd ? q_head.id : best_id_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg       <= 1'b0;
            best_dist_reg <= MAX31;
            best_id_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (take && q_head.last) begin
                any_reg       <= 1'b0;
                best_dist_reg <= MAX31;
                best_id_reg   <= '0;
                m_valid_reg   <= 1'b1;
            end else begin
                if (take) begin
                    any_reg       <= any_next;
                    best_dist_reg <= dist_next;
                    best_id_reg   <= id_next;
                end
                if (m_ready)
                    m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (take && q_head.last) begin
            m_hit_reg  <= any_next;
            m_id_reg   <= any_next ? id_next : '0;
            m_dist_reg <= any_next ? dist_next : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;
    assign m_id    = m_id_reg;
    assign m_dist  = m_dist_reg;

endmodule

/* sv/ray_bounding_sphere_nearest_pick_top.sv */
// Nearest bounding-sphere pick along a ray: one body in, one result per scene.
// Bodies are tested one at a time; the front end accepts the next only when idle. A body
// that reaches the distance root takes a pass of the shared square root unit, which
// resolves one root bit per cycle; an early miss skips it, and a box adds a radius root.
// A last body's result passes through the queue and the back end's result register.
// Reset (aresetn low, synchronous): origin 0, direction +z 1.0, no hit held, queue empty.
module ray_bounding_sphere_nearest_pick_top
    import rbsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dim_x[30:0] dim_y[61:31] dim_z[92:62] center_x[124:93] center_y[156:125]
    // center_z[188:157] body_id[204:189], zero pad [207:205]
    input  logic [207:0] s_tdata,
    // shape_kind[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_id[15:0] hit_distance[46:16], zero pad [47]
    output logic [47:0]  m_tdata,
    // hit[0]
    output logic         m_tuser
);

    logic [30:0] dim_in    [3];
    logic [31:0] center_in [3];
    logic        q_push, q_full, q_pop, q_valid;
    test_t       q_in, q_head;
    logic [15:0] hit_id;
    logic [30:0] hit_dist;

    assign cfg_ready = 1'b1;

    // Unpack the body
    assign dim_in[0]    = s_tdata[30:0];
    assign dim_in[1]    = s_tdata[61:31];
    assign dim_in[2]    = s_tdata[92:62];
    assign center_in[0] = s_tdata[124:93];
    assign center_in[1] = s_tdata[156:125];
    assign center_in[2] = s_tdata[188:157];

    rbsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .kind_in   (s_tuser),
        .dim_in    (dim_in),
        .center_in (center_in),
        .id_in     (s_tdata[204:189]),
        .last_in   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    rbsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    rbsp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_hit   (m_tuser),
        .m_id    (hit_id),
        .m_dist  (hit_dist)
    );

    // Pack the result
    assign m_tdata = {1'b0, hit_dist, hit_id};

endmodule

/* bench/tb_ray_bounding_sphere_nearest_pick_top.sv */
// Self-checking bench for the ray bounding-sphere nearest pick block.
// Drives ray setups and scenes of bodies, predicts each scene's nearest hit and
// checks every result transfer. Depends on rbsp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_ray_bounding_sphere_nearest_pick_top;
    import rbsp_pkg::*;

    typedef struct {
        kind_t              kind;
        logic [30:0]        dim_x, dim_y, dim_z;
        logic signed [31:0] ctr_x, ctr_y, ctr_z;
        logic [15:0]        id;
        logic               last;
    } body_t;

    typedef struct {
        logic        hit;
        logic [15:0] id;
        logic [30:0] distance;
    } pick_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tuser;

    // Ray setup as last written, and the running scene of the predictor
    logic signed [31:0] ray_org [3];
    logic signed [17:0] ray_dir [3];
    logic [30:0]        near_dist;
    logic [15:0]        near_id;
    logic               near_valid;

    body_t pending_bodies[$];
    pick_t expected_picks[$];
    body_t held_body;

    int  errors = 0;
    int  bodies_sent = 0;
    int  picks_seen = 0;
    int  hits_seen = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  hold_left = 0;
    bit  hold_ask = 0;
    bit  quiet = 0;

    ray_bounding_sphere_nearest_pick_top i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Test one accepted body against the ray; emit the scene's pick on its last body
    task automatic track_body(input body_t bd);
        logic [63:0] rad, occ, p, s;
        longint      oc [3];
        longint      dot, b, t0, t1, tv;
        pick_t       pk;
        bit          hit;
        case (bd.kind)
            KIND_SPHERE:  rad = 64'(bd.dim_x);
            KIND_BOX:     rad = isqrt(64'(bd.dim_x) * 64'(bd.dim_x)
                                      + 64'(bd.dim_y) * 64'(bd.dim_y)
                                      + 64'(bd.dim_z) * 64'(bd.dim_z));
            KIND_CAPSULE: rad = 64'(bd.dim_x) + 64'(bd.dim_y);
            default:      rad = 64'(HALF_Q);
        endcase
        if (rad > 64'(MAX31)) rad = 64'(MAX31);
        oc[0] = clamp32(longint'(ray_org[0]) - bd.ctr_x);
        oc[1] = clamp32(longint'(ray_org[1]) - bd.ctr_y);
        oc[2] = clamp32(longint'(ray_org[2]) - bd.ctr_z);
        dot = 0;
        occ = 0;
        for (int i = 0; i < 3; i++) begin
            dot += oc[i] * longint'(ray_dir[i]);
            occ += absval(oc[i]) * absval(oc[i]);
        end
        b = clamp32(dot >>> 16);
        p = absval(b) * absval(b) + rad * rad;
        hit = 0;
        tv = 0;
        if (p >= occ) begin
            s = isqrt(p - occ);
            t0 = -b - longint'(s);
            t1 = -b + longint'(s);
            if (t0 > 0) begin
                tv = t0;
                hit = 1;
            end else if (t1 > 0) begin
                tv = t1;
                hit = 1;
            end
            if (tv > 64'sd2147483647) tv = 64'sd2147483647;
        end
        // First hit is taken on the valid bit; ties keep the earlier body
        if (hit && (!near_valid || tv < near_dist)) begin
            near_dist = tv[30:0];
            near_id = bd.id;
            near_valid = 1'b1;
        end
        if (bd.last) begin
            pk.hit = near_valid;
            pk.id = near_valid ? near_id : 16'd0;
            pk.distance = near_valid ? near_dist : 31'd0;
            expected_picks.push_back(pk);
            near_valid = 1'b0;
            near_dist = MAX31;
            near_id = 16'd0;
        end
    endtask

    // Body sender: load queued bodies, insert random gaps, predict on each transfer
    always @(posedge aclk) begin : body_sender
        bit take;
        bit nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            take = s_tvalid && s_tready;
            if (take) begin
                track_body(held_body);
                bodies_sent++;
            end
            if (!s_tvalid || take) begin
                nv = 0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bodies.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 11) - 1;
                    end else begin
                        held_body = pending_bodies.pop_front();
                        s_tdata <= {3'b0, held_body.id, held_body.ctr_z, held_body.ctr_y,
                                    held_body.ctr_x, held_body.dim_z, held_body.dim_y,
                                    held_body.dim_x};
                        s_tuser <= held_body.kind;
                        s_tlast <= held_body.last;
                        nv = 1;
                    end
                end
                s_tvalid <= nv;
            end
        end
    end

    // Pick receiver: check each transfer, stall in bursts, honor a long hold-off
    always @(posedge aclk) begin : pick_receiver
        bit    rdy;
        pick_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                picks_seen++;
                if (m_tuser) hits_seen++;
                if (expected_picks.size() == 0) begin
                    $display("%0t: unexpected pick: hit %0b id %0h dist %0h", $time,
                             m_tuser, m_tdata[15:0], m_tdata[46:16]);
                    errors++;
                end else begin
                    want = expected_picks.pop_front();
                    if (m_tuser !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:0] !== want.id) begin
                        $display("%0t: hit_id expected %0h actual %0h", $time, want.id,
                                 m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[46:16] !== want.distance) begin
                        $display("%0t: hit_distance expected %0h actual %0h", $time,
                                 want.distance, m_tdata[46:16]);
                        errors++;
                    end
                end
            end
            rdy = 0;
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_ask) begin
                hold_ask = 0;
                hold_left = 700;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(1, 11) - 1;
            end else begin
                rdy = 1;
            end
            m_tready <= rdy;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= REG_ORIGIN_Z) ray_org[idx] = val;
        else ray_dir[idx - REG_DIR_X] = val[17:0];
    endtask

    task automatic set_ray(input logic [31:0] ox, oy, oz, input logic [17:0] dx, dy, dz);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, {{14{dx[17]}}, dx});
        write_reg(REG_DIR_Y, {{14{dy[17]}}, dy});
        write_reg(REG_DIR_Z, {{14{dz[17]}}, dz});
    endtask

    function automatic body_t mk_body(input kind_t k, input logic [30:0] dx, dy, dz,
                                      input logic [31:0] cx, cy, cz,
                                      input logic [15:0] id, input logic last);
        body_t bd;
        bd.kind = k;
        bd.dim_x = dx; bd.dim_y = dy; bd.dim_z = dz;
        bd.ctr_x = cx; bd.ctr_y = cy; bd.ctr_z = cz;
        bd.id = id;
        bd.last = last;
        return bd;
    endfunction

    // Random body: mostly placed near the current ray, sometimes anywhere
    function automatic body_t rand_body(input logic last);
        body_t  bd;
        longint k, c;
        bd.kind = kind_t'($urandom_range(0, 3));
        bd.id = 16'($urandom);
        bd.last = last;
        if ($urandom_range(0, 9) == 0) begin
            bd.dim_x = 31'($urandom); bd.dim_y = 31'($urandom); bd.dim_z = 31'($urandom);
            bd.ctr_x = $urandom; bd.ctr_y = $urandom; bd.ctr_z = $urandom;
        end else begin
            bd.dim_x = 31'($urandom_range(0, 1 << 20));
            bd.dim_y = 31'($urandom_range(0, 1 << 19));
            bd.dim_z = 31'($urandom_range(0, 1 << 19));
            k = $urandom_range(0, 1 << 24);
            if ($urandom_range(0, 5) == 0) k = -k;
            for (int i = 0; i < 3; i++) begin
                c = clamp32(longint'(ray_org[i]) + ((k * ray_dir[i]) >>> 16)
                            + $signed($urandom_range(0, 1 << 21)) - (1 << 20));
                if (i == 0) bd.ctr_x = 32'(c);
                else if (i == 1) bd.ctr_y = 32'(c);
                else bd.ctr_z = 32'(c);
            end
        end
        return bd;
    endfunction

    task automatic wait_idle();
        while (pending_bodies.size() > 0 || s_tvalid || expected_picks.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic queue_scenes(input int count);
        int n;
        body_t bd;
        for (int i = 0; i < count; ) begin
            n = $urandom_range(1, 8);
            for (int j = 0; j < n; j++) begin
                // Repeat the previous body under a new id now and then for ties
                if (j > 0 && $urandom_range(0, 7) == 0) begin
                    bd.id = 16'($urandom);
                    bd.last = (j == n - 1);
                end else begin
                    bd = rand_body(j == n - 1);
                end
                pending_bodies.push_back(bd);
                i++;
            end
        end
    endtask

    initial begin
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, 18'sh1_0000};
        near_valid = 0;
        near_dist = MAX31;
        near_id = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed scene checks with the reset ray: origin 0, direction +z
        pending_bodies.push_back(mk_body(KIND_SPHERE, 31'h1_0000, 0, 0, 0, 0, 32'ha_0000,
                                         16'd1, 0));
        pending_bodies.push_back(mk_body(KIND_SPHERE, 31'h1_0000, 0, 0, 0, 0, 32'ha_0000,
                                         16'd2, 1));
        pending_bodies.push_back(mk_body(KIND_SPHERE, 0, 0, 0, 0, 0, 32'ha_0000, 16'd3, 1));
        pending_bodies.push_back(mk_body(KIND_SPHERE, 31'h1_0000, 0, 0, 0, 0, 32'hfff6_0000,
                                         16'd4, 1));
        pending_bodies.push_back(mk_body(KIND_SPHERE, 31'h5_0000, 0, 0, 0, 0, 0, 16'd5, 1));
        pending_bodies.push_back(mk_body(KIND_BOX, MAX31, MAX31, MAX31, 0, 0, 0, 16'd6, 0));
        pending_bodies.push_back(mk_body(KIND_CAPSULE, MAX31, MAX31, 0, 0, 0, 32'h7fff_ffff,
                                         16'd7, 0));
        pending_bodies.push_back(mk_body(KIND_UNKNOWN, MAX31, MAX31, MAX31, 0, 0,
                                         32'h3_0000, 16'd8, 0));
        pending_bodies.push_back(mk_body(KIND_SPHERE, 0, 0, 0, 32'h8000_0000, 0, 32'h5_0000,
                                         16'd9, 1));
        pending_bodies.push_back(mk_body(KIND_SPHERE, MAX31, 0, 0, 0, 0, 32'h7fff_ffff,
                                         16'hffff, 1));
        pending_bodies.push_back(mk_body(KIND_UNKNOWN, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                                         32'h8000_0000, 16'hffff, 0));
        pending_bodies.push_back(mk_body(KIND_BOX, 31'h1_0000, 31'h2_0000, 31'h2_0000, 0, 0,
                                         32'h8_0000, 16'h0, 1));
        queue_scenes(60);
        wait_idle();

        // Axis ray with a long receiver hold-off so the block backs up
        set_ray(0, 0, 0, 18'sh1_0000, 0, 0);
        hold_ask = 1;
        queue_scenes(200);
        wait_idle();

        set_ray(32'h7fff_ffff, 32'h8000_0000, 0, -18'sh1_0000, 0, 0);
        queue_scenes(150);
        wait_idle();

        set_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, -18'sh1_0000, 18'sh1_0000);
        queue_scenes(100);
        wait_idle();

        set_ray(0, 0, 32'h1000_0000, 0, 0, -18'sh1_0000);
        queue_scenes(150);
        wait_idle();

        // Direction registers at their 18-bit extremes, well off unit length
        set_ray($urandom, $urandom, $urandom, 18'sh1_ffff, 18'sh2_0000, 18'sh1_0000);
        queue_scenes(100);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            set_ray($urandom_range(0, 1 << 24), $urandom, $urandom_range(0, 1 << 22),
                    18'($urandom), 18'($urandom), 18'($urandom));
            queue_scenes(120);
            wait_idle();
        end

        set_ray(32'h10_0000, 32'hfff0_0000, 0, 18'sd46341, 0, 18'sd46341);
        quiet = 1;
        queue_scenes(150);
        wait_idle();

        $display("Sent %0d bodies over 11 ray setups; %0d scene picks checked, %0d hits.",
                 bodies_sent, picks_seen, hits_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Timeout with %0d bodies queued and %0d picks outstanding.",
                 pending_bodies.size(), expected_picks.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
